[design/cross_color_median_residual_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cross colour median residual core
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef CROSS_COLOR_MEDIAN_RESIDUAL_CORE_DEFINES_SVH
`define CROSS_COLOR_MEDIAN_RESIDUAL_CORE_DEFINES_SVH

// Check a property outside reset.
`define CCMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define CCMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/ccmr_pkg.sv]
// ----------------------------------------------------------------------------
// Cross colour median residual package
// Field widths, register indexes and the arithmetic helpers of the core.
// ----------------------------------------------------------------------------
package ccmr_pkg;

  localparam int unsigned PIX_W     = 8;   // colour component
  localparam int unsigned TV_W      = 9;   // transformed value word
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned IW_W      = 13;  // image_width register
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;
  localparam logic [IW_W-1:0] IMAGE_WIDTH_RST = 13'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_FROM_GREEN  = 2'd0,
    CFG_BLUE_FROM_GREEN = 2'd1,
    CFG_BLUE_FROM_RED   = 2'd2,
    CFG_IMAGE_WIDTH     = 2'd3
  } cfg_reg_e;

  // x * (gain + 1) >> 8, never above 255
  function automatic logic [PIX_W-1:0] scaled(input logic [GAIN_W-1:0] gain,
                                              input logic [PIX_W-1:0]  x);
    logic [PIX_W+GAIN_W:0] prod;
    prod = {{(GAIN_W+1){1'b0}}, x} * {{PIX_W{1'b0}}, ({1'b0, gain} + 9'd1)};
    return prod[PIX_W+GAIN_W-1:GAIN_W];
  endfunction

  // Median of left, top and the planar gradient, all modulo 512
  function automatic logic [TV_W-1:0] median_pred(input logic [TV_W-1:0] l,
                                                  input logic [TV_W-1:0] t,
                                                  input logic [TV_W-1:0] tl);
    logic [TV_W-1:0] grad;
    logic [TV_W-1:0] lo;
    logic [TV_W-1:0] hi;
    grad = l + t - tl;
    lo   = (l < t) ? l : t;
    hi   = (l < t) ? t : l;
    if (grad < lo) begin
      return lo;
    end else if (grad > hi) begin
      return hi;
    end
    return grad;
  endfunction

endpackage

[design/cross_color_median_residual_core.sv]
// ----------------------------------------------------------------------------
// Cross colour median residual core
// Colour decorrelation followed by median edge prediction of red and blue.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel in raster order, one transaction per
//   pixel; s_axis_tuser marks the first pixel of a frame. Each pixel yields
//   one transaction on m_axis carrying the red and blue residuals.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i
//   while the stream is idle.
// Timing:
//   One pixel per clock sustained while no stall holds the pipeline. The
//   colour transform and the registered row store read fill the prediction
//   stage registers; prediction then fills the output register. The row
//   store read port sets the first stage; the previous pixel's write is
//   forwarded when both fall on the same column.
// Reset:
//   Gains clear to 0, the width returns to 256, the pipeline empties and the
//   next pixel is taken as the first pixel of a frame. The row stores are not
//   cleared; the first row of a frame never uses them for prediction.
// Stall:
//   While m_axis_tready is low with a result pending, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "cross_color_median_residual_core_defines.svh"

module cross_color_median_residual_core
  import ccmr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  // pixel input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // green_in, red_in, blue_in
  input  logic                 s_axis_tuser,   // frame_start
  // residual output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata    // red_residual, blue_residual
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned CNTW = CW + 1;

  // configuration
  logic [GAIN_W-1:0] r_from_g_q, b_from_g_q, b_from_r_q;
  logic [IW_W-1:0]   image_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_from_g_q    <= '0;
      b_from_g_q    <= '0;
      b_from_r_q    <= '0;
      image_width_q <= IMAGE_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_RED_FROM_GREEN:  r_from_g_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_BLUE_FROM_GREEN: b_from_g_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_BLUE_FROM_RED:   b_from_r_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_IMAGE_WIDTH:     image_width_q <= cfg_wdata_i[IW_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic advance;
  logic accept;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;

  // input fields
  logic [PIX_W-1:0] green_in, red_in, blue_in;
  assign green_in = s_axis_tdata[7:0];
  assign red_in   = s_axis_tdata[15:8];
  assign blue_in  = s_axis_tdata[23:16];

  // effective width, clamped to 1 .. MAX_WIDTH
  logic [CNTW-1:0] eff_width;
  always_comb begin
    if (image_width_q == '0) begin
      eff_width = CNTW'(1);
    end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
      eff_width = CNTW'(MAX_WIDTH);
    end else begin
      eff_width = CNTW'(image_width_q);
    end
  end

  // column tracking at the input
  logic [CW-1:0]   col_q, col_d;
  logic            first_q, first_d;
  logic [CW-1:0]   col_pre, col_a;
  logic            first_pre, first_a;
  logic [CNTW-1:0] col_inc;

  always_comb begin
    col_pre   = s_axis_tuser ? '0 : col_q;
    first_pre = s_axis_tuser ? 1'b1 : first_q;
    // start a new row when the width has shrunk under the column
    if ({1'b0, col_pre} >= eff_width) begin
      col_a   = '0;
      first_a = 1'b0;
    end else begin
      col_a   = col_pre;
      first_a = first_pre;
    end
    col_inc = {1'b0, col_a} + CNTW'(1);
    if (col_inc >= eff_width) begin
      col_d   = '0;
      first_d = 1'b0;
    end else begin
      col_d   = col_inc[CW-1:0];
      first_d = first_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else if (accept) begin
      col_q   <= col_d;
      first_q <= first_d;
    end
  end

  // colour transform
  logic [TV_W-1:0] tr_a, tb_a;
  always_comb begin
    tr_a = {1'b0, red_in} - {1'b0, scaled(r_from_g_q, green_in)};
    tb_a = {1'b0, blue_in} - {1'b0, scaled(b_from_g_q, green_in)}
         - {1'b0, scaled(b_from_r_q, red_in)};
  end

  // prediction stage registers
  logic            b_valid_q;
  logic [CW-1:0]   b_col_q;
  logic            b_first_q;
  logic [TV_W-1:0] b_tr_q, b_tb_q;
  logic            b_fwd_q;
  logic [TV_W-1:0] b_fwd_r_q, b_fwd_b_q;
  logic [TV_W-1:0] rd_r_q, rd_b_q;
  logic            b_write;

  assign b_write = b_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q   <= col_a;
      b_first_q <= first_a;
      b_tr_q    <= tr_a;
      b_tb_q    <= tb_a;
      // the pixel in the prediction stage writes this column on the same edge
      b_fwd_q   <= b_valid_q && (b_col_q == col_a);
      b_fwd_r_q <= b_tr_q;
      b_fwd_b_q <= b_tb_q;
    end
  end

  // row stores
  logic [TV_W-1:0] red_mem  [MAX_WIDTH];
  logic [TV_W-1:0] blue_mem [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (b_write) begin
      red_mem[b_col_q]  <= b_tr_q;
      blue_mem[b_col_q] <= b_tb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_r_q <= red_mem[col_a];
      rd_b_q <= blue_mem[col_a];
    end
  end

  // neighbours
  logic [TV_W-1:0] left_r_q, left_b_q, tl_r_q, tl_b_q;
  logic [TV_W-1:0] top_r, top_b, pred_r, pred_b;
  logic [TV_W-1:0] diff_r, diff_b;

  always_comb begin
    top_r = b_fwd_q ? b_fwd_r_q : rd_r_q;
    top_b = b_fwd_q ? b_fwd_b_q : rd_b_q;
    if (b_first_q) begin
      pred_r = (b_col_q == '0) ? '0 : left_r_q;
      pred_b = (b_col_q == '0) ? '0 : left_b_q;
    end else if (b_col_q == '0) begin
      pred_r = top_r;
      pred_b = top_b;
    end else begin
      pred_r = median_pred(left_r_q, top_r, tl_r_q);
      pred_b = median_pred(left_b_q, top_b, tl_b_q);
    end
    diff_r = b_tr_q - pred_r;
    diff_b = b_tb_q - pred_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_r_q <= '0;
      left_b_q <= '0;
      tl_r_q   <= '0;
      tl_b_q   <= '0;
    end else if (b_write) begin
      left_r_q <= b_tr_q;
      left_b_q <= b_tb_q;
      tl_r_q   <= top_r;
      tl_b_q   <= top_b;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_write) begin
      m_axis_tdata <= {diff_b[PIX_W-1:0], diff_r[PIX_W-1:0]};
    end
  end

  // assertions
  `CCMR_ASSERT(a_accept_fills_stage, accept |=> b_valid_q,
               "accepted transaction did not reach the prediction stage")
  `CCMR_ASSERT(a_stage_holds, (b_valid_q && !advance) |=> b_valid_q,
               "prediction stage dropped a pixel under stall")
  `CCMR_ASSERT(a_stage_to_output, b_write |=> m_axis_tvalid,
               "prediction stage result did not reach the output")
  `CCMR_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!m_axis_tvalid && !b_valid_q),
                      "pipeline not emptied by reset")

endmodule

[verif/cross_color_median_residual_core_test.sv]
// ----------------------------------------------------------------------------
// Cross colour median residual core testbench
// A pixel driver and a residual monitor run on clocked always blocks. Each
// accepted pixel is predicted in the bench: colour decorrelation first, then
// median edge prediction against a private copy of the row stores. Results
// are compared field by field, in order. Phases change the gains and the
// width between streams, while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cross_color_median_residual_core_test;
  import ccmr_pkg::*;

  localparam int unsigned ROW_DEPTH = 4096;

  typedef enum int {MODE_RANDOM, MODE_SMOOTH, MODE_EXTREME} content_e;

  typedef struct {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  // red_residual in the low byte, as on m_axis_tdata
  typedef struct packed {
    logic [7:0] blue_residual;
    logic [7:0] red_residual;
  } residual_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata  = '0;   // green_in, red_in, blue_in
  logic                 s_axis_tuser  = 1'b0; // frame_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;         // red_residual, blue_residual

  cross_color_median_residual_core #(
    .MAX_WIDTH(ROW_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the configuration registers
  logic [7:0]  gain_rg    = 8'd0;
  logic [7:0]  gain_bg    = 8'd0;
  logic [7:0]  gain_br    = 8'd0;
  logic [12:0] width_reg  = IMAGE_WIDTH_RST;

  // Shadow of the prediction state
  logic [8:0]  row_red  [ROW_DEPTH];
  logic [8:0]  row_blue [ROW_DEPTH];
  logic [8:0]  prev_red   = '0;
  logic [8:0]  prev_blue  = '0;
  logic [8:0]  diag_red   = '0;
  logic [8:0]  diag_blue  = '0;
  int unsigned next_col   = 0;
  bit          first_row_active = 1'b1;

  pixel_t      pending_pixels[$];
  residual_t   expected_residuals[$];
  int          error_count = 0;

  int          burst_left  = 0;
  int          gap_left    = 0;
  int          rx_hold_req  = 0;
  int          rx_hold_seen = 0;
  int          rx_hold_left = 0;
  int          rx_mode      = 0;
  int          rx_mode_left = 0;
  logic [7:0]  walk_g = 8'd128;
  logic [7:0]  walk_r = 8'd128;
  logic [7:0]  walk_b = 8'd128;

  function automatic logic [7:0] gain_term(input logic [7:0] gain, input logic [7:0] x);
    logic [16:0] prod;
    prod = {9'd0, x} * {9'd0, gain} + {9'd0, x};
    return prod[15:8];
  endfunction

  // Median of left, top and the planar gradient, all unsigned 9-bit
  function automatic logic [8:0] med_edge(input logic [8:0] lf, input logic [8:0] up,
                                          input logic [8:0] dg);
    logic [8:0] plane;
    logic [8:0] mn;
    logic [8:0] mx;
    plane = lf + up - dg;
    mn = (up < lf) ? up : lf;
    mx = (up < lf) ? lf : up;
    return (plane < mn) ? mn : ((plane > mx) ? mx : plane);
  endfunction

  function automatic residual_t predict_residual(input pixel_t px);
    int unsigned w;
    int unsigned col;
    logic [8:0]  t_red;
    logic [8:0]  t_blue;
    logic [8:0]  up_red;
    logic [8:0]  up_blue;
    logic [8:0]  p_red;
    logic [8:0]  p_blue;
    logic [8:0]  d_red;
    logic [8:0]  d_blue;
    residual_t   res;
    w = (width_reg == 0) ? 1 : ((width_reg > ROW_DEPTH) ? ROW_DEPTH : width_reg);
    if (px.frame_start) begin
      next_col = 0;
      first_row_active = 1'b1;
    end
    if (next_col >= w) begin
      next_col = 0;
      first_row_active = 1'b0;
    end
    col = next_col;
    t_red  = {1'b0, px.red} - {1'b0, gain_term(gain_rg, px.green)};
    t_blue = {1'b0, px.blue} - {1'b0, gain_term(gain_bg, px.green)}
             - {1'b0, gain_term(gain_br, px.red)};
    up_red  = row_red[col];
    up_blue = row_blue[col];
    if (first_row_active) begin
      p_red  = (col == 0) ? 9'd0 : prev_red;
      p_blue = (col == 0) ? 9'd0 : prev_blue;
    end else if (col == 0) begin
      p_red  = up_red;
      p_blue = up_blue;
    end else begin
      p_red  = med_edge(prev_red, up_red, diag_red);
      p_blue = med_edge(prev_blue, up_blue, diag_blue);
    end
    d_red  = t_red - p_red;
    d_blue = t_blue - p_blue;
    res.red_residual  = d_red[7:0];
    res.blue_residual = d_blue[7:0];
    diag_red  = up_red;
    diag_blue = up_blue;
    row_red[col]  = t_red;
    row_blue[col] = t_blue;
    prev_red  = t_red;
    prev_blue = t_blue;
    next_col = col + 1;
    if (next_col >= w) begin
      next_col = 0;
      first_row_active = 1'b0;
    end
    return res;
  endfunction

  // Pixel driver: bursts of random length with random gaps
  always @(posedge clk_i) begin
    pixel_t px;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        px.green       = s_axis_tdata[7:0];
        px.red         = s_axis_tdata[15:8];
        px.blue        = s_axis_tdata[23:16];
        px.frame_start = s_axis_tuser;
        expected_residuals.push_back(predict_residual(px));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          px = pending_pixels.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {px.blue, px.red, px.green};
          s_axis_tuser  <= px.frame_start;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = 150;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(16, 96);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  task automatic report_mismatch(input string field, input int exp_v, input int act_v);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp_v, act_v);
    end
  endtask

  // Residual monitor
  always @(posedge clk_i) begin
    residual_t exp_r;
    residual_t act_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_r = residual_t'(m_axis_tdata);
      if (expected_residuals.size() == 0) begin
        report_mismatch("unexpected transaction, tdata", -1, m_axis_tdata);
      end else begin
        exp_r = expected_residuals.pop_front();
        if (act_r.red_residual !== exp_r.red_residual) begin
          report_mismatch("red_residual", exp_r.red_residual, act_r.red_residual);
        end
        if (act_r.blue_residual !== exp_r.blue_residual) begin
          report_mismatch("blue_residual", exp_r.blue_residual, act_r.blue_residual);
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[CFG_DAT_W-1:0];
    case (idx)
      CFG_RED_FROM_GREEN:  gain_rg   = value[7:0];
      CFG_BLUE_FROM_GREEN: gain_bg   = value[7:0];
      CFG_BLUE_FROM_RED:   gain_br   = value[7:0];
      default:             width_reg = value[12:0];
    endcase
  endtask

  task automatic set_config(input int unsigned rg, input int unsigned bg,
                            input int unsigned br, input int unsigned width);
    write_reg(CFG_RED_FROM_GREEN, rg);
    write_reg(CFG_BLUE_FROM_GREEN, bg);
    write_reg(CFG_BLUE_FROM_RED, br);
    write_reg(CFG_IMAGE_WIDTH, width);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] walk_step(input logic [7:0] v);
    return v + 8'($urandom_range(0, 10)) - 8'd5;
  endfunction

  function automatic int unsigned pick_gain();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 5))
      0:       return 1;
      1:       return 2;
      2, 3:    return $urandom_range(3, 12);
      4:       return $urandom_range(13, 40);
      default: return 0;
    endcase
  endfunction

  // Queue one stream, then hold until every residual of it has arrived
  task automatic run_phase(input int n_items, input bit first_fs, input content_e mode,
                           input bit noise, input bit long_hold);
    pixel_t px;
    @(negedge clk_i);
    for (int i = 0; i < n_items; i++) begin
      case (mode)
        MODE_EXTREME: begin
          px.green = pick_level();
          px.red   = pick_level();
          px.blue  = pick_level();
        end
        MODE_SMOOTH: begin
          walk_g = walk_step(walk_g);
          walk_r = walk_step(walk_r);
          walk_b = walk_step(walk_b);
          px.green = walk_g;
          px.red   = walk_r;
          px.blue  = walk_b;
        end
        default: begin
          px.green = 8'($urandom_range(0, 255));
          px.red   = 8'($urandom_range(0, 255));
          px.blue  = 8'($urandom_range(0, 255));
        end
      endcase
      px.frame_start = (i == 0) ? first_fs : (noise && $urandom_range(0, 49) == 0);
      pending_pixels.push_back(px);
    end
    if (long_hold) begin
      rx_hold_req++;
    end
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_residuals.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // No frame_start after reset: first pixel still starts a frame
    set_config(255, 255, 255, 4);
    run_phase(6, 1'b0, MODE_EXTREME, 1'b0, 1'b0);
    // Width shrunk below the current column: new row without frame_start
    set_config(0, 0, 0, 2);
    run_phase(5, 1'b0, MODE_EXTREME, 1'b0, 1'b0);
    // Width of zero behaves as one column
    set_config(128, 1, 200, 0);
    run_phase(5, 1'b1, MODE_EXTREME, 1'b0, 1'b0);
    set_config(0, 255, 0, ROW_DEPTH);
    run_phase(6, 1'b1, MODE_EXTREME, 1'b0, 1'b0);

    for (int k = 0; k < 10; k++) begin
      set_config(pick_gain(), pick_gain(), pick_gain(), pick_width());
      run_phase(36, 1'b1, content_e'(k % 3), 1'b1, k == 3);
    end

    // Width above the store depth: clamps to the store depth
    set_config(pick_gain(), pick_gain(), pick_gain(), 8191);
    run_phase(34, 1'b1, MODE_SMOOTH, 1'b0, 1'b0);

    set_config(pick_gain(), pick_gain(), pick_gain(), pick_width());
    run_phase(36, 1'b1, MODE_RANDOM, 1'b1, 1'b0);

    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
